FILE: hw/rtl/ragt_pkg.sv
// ----------------------------------------------------------------------------
// ragt_pkg
// Shared types and codes for the random access and grant timer.
// ----------------------------------------------------------------------------
package ragt_pkg;

	// event codes carried in the kind field
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_RESP  = 2'd1,
		KIND_GRANT = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_TRIES       = 2'd0,
		CFG_MIN_BACKOFF     = 2'd1,
		CFG_MAX_BACKOFF     = 2'd2,
		CFG_RESPONSE_WINDOW = 2'd3
	} cfg_idx_t;

	localparam logic [3:0] MAX_TRIES_RST       = 4'd0;
	localparam logic [7:0] MIN_BACKOFF_RST     = 8'd0;
	localparam logic [7:0] MAX_BACKOFF_RST     = 8'd1;
	localparam logic [3:0] RESPONSE_WINDOW_RST = 4'd3;

	// controller state
	typedef struct packed {
		logic [7:0]  backoff_timer;
		logic [3:0]  response_timer;
		logic        request_pending;
		logic [3:0]  try_count;
		logic        report_flag;
		logic        grant_valid;
		logic        grant_is_periodic;
		logic [9:0]  period_counter;
		logic [15:0] expiry_counter;
		logic [9:0]  stored_period;
	} ctl_state_t;

	// one result word
	typedef struct packed {
		logic rac_request;
		logic tx_opportunity;
		logic report_due;
		logic grant_expired;
	} result_t;

endpackage

FILE: hw/rtl/ragt_if.sv
// ----------------------------------------------------------------------------
// ragt_evt_if / ragt_rsp_if
// Valid/ready channels for event words and result words.
// ----------------------------------------------------------------------------
interface ragt_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        data_pending;
	logic        rac_success;
	logic [7:0]  backoff_draw;
	logic        grant_periodic;
	logic [9:0]  grant_period;
	logic [15:0] grant_expiration;

	modport source (
		output valid, kind, data_pending, rac_success, backoff_draw,
		       grant_periodic, grant_period, grant_expiration,
		input  ready
	);
	modport sink (
		input  valid, kind, data_pending, rac_success, backoff_draw,
		       grant_periodic, grant_period, grant_expiration,
		output ready
	);
endinterface

interface ragt_rsp_if;
	logic valid;
	logic ready;
	logic rac_request;
	logic tx_opportunity;
	logic report_due;
	logic grant_expired;

	modport source (
		output valid, rac_request, tx_opportunity, report_due, grant_expired,
		input  ready
	);
	modport sink (
		input  valid, rac_request, tx_opportunity, report_due, grant_expired,
		output ready
	);
endinterface

FILE: hw/rtl/random_access_and_grant_timer.sv
// Pipeline: an event taken is registered in the input stage, and its result in the
// result stage together with the updated controller state.
// Throughput: one event per cycle unless the sink stalls; the result register frees the
// input stage whenever the result is taken or empty, so a stalled sink costs no bubble.
// Reset: arst_n clears all controller state, both valid flags and the
// configuration registers to their defaults, asynchronously.
// ----------------------------------------------------------------------------
// random_access_and_grant_timer
// Uplink access request, backoff and grant timing controller, one event per word.
// ----------------------------------------------------------------------------
module random_access_and_grant_timer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ragt_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ragt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ragt_evt_if.sink                        evt,
	ragt_rsp_if.source                      rsp
);
	import ragt_pkg::*;

	// configuration
	logic [3:0] max_tries_q;
	logic [7:0] min_backoff_q;
	logic [7:0] max_backoff_q;
	logic [3:0] response_window_q;

	// input stage
	logic        valid_s1;
	kind_t       kind_s1;
	logic        data_pending_s1;
	logic        rac_success_s1;
	logic [7:0]  backoff_draw_s1;
	logic        grant_periodic_s1;
	logic [9:0]  grant_period_s1;
	logic [15:0] grant_expiration_s1;

	// state and result stage
	ctl_state_t st_q, st_nxt;
	result_t    res_s2, res_nxt;
	logic       valid_s2;

	logic       advance;
	logic       run_check;
	logic       give;
	logic [4:0] tries_inc;
	logic [7:0] draw_lo;
	logic [7:0] draw_clamped;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tries_q       <= MAX_TRIES_RST;
			min_backoff_q     <= MIN_BACKOFF_RST;
			max_backoff_q     <= MAX_BACKOFF_RST;
			response_window_q <= RESPONSE_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_MAX_TRIES:       max_tries_q       <= cfg_wdata[3:0];
				CFG_MIN_BACKOFF:     min_backoff_q     <= cfg_wdata;
				CFG_MAX_BACKOFF:     max_backoff_q     <= cfg_wdata;
				CFG_RESPONSE_WINDOW: response_window_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			kind_s1             <= kind_t'(evt.kind);
			data_pending_s1     <= evt.data_pending;
			rac_success_s1      <= evt.rac_success;
			backoff_draw_s1     <= evt.backoff_draw;
			grant_periodic_s1   <= evt.grant_periodic;
			grant_period_s1     <= evt.grant_period;
			grant_expiration_s1 <= evt.grant_expiration;
		end
	end

	assign tries_inc    = {1'b0, st_q.try_count} + 5'd1;
	assign draw_lo      = (backoff_draw_s1 < min_backoff_q) ? min_backoff_q : backoff_draw_s1;
	assign draw_clamped = (draw_lo > max_backoff_q) ? max_backoff_q : draw_lo;

	always_comb begin
		st_nxt    = st_q;
		res_nxt   = '0;
		run_check = 1'b0;
		give      = 1'b0;
		unique case (kind_s1)
			KIND_TICK: begin
				if (!st_q.grant_valid) begin
					run_check = 1'b1;
				end else if (st_q.grant_is_periodic) begin
					if (st_q.expiry_counter == '0) begin
						st_nxt.grant_valid       = 1'b0;
						st_nxt.grant_is_periodic = 1'b0;
						res_nxt.grant_expired    = 1'b1;
						run_check                = 1'b1;
					end else begin
						st_nxt.expiry_counter = st_q.expiry_counter - 16'd1;
						if (st_q.period_counter > 10'd1) begin
							st_nxt.period_counter = st_q.period_counter - 10'd1;
						end else begin
							st_nxt.period_counter = st_q.stored_period;
							give                  = 1'b1;
						end
					end
				end else begin
					give = 1'b1;
				end
				if (give) begin
					res_nxt.tx_opportunity = 1'b1;
					res_nxt.report_due     = st_q.report_flag;
					st_nxt.report_flag     = 1'b0;
					if (!st_q.grant_is_periodic) begin
						st_nxt.grant_valid = 1'b0;
					end
				end
				// access check: backoff, then response window, then duplicate drop
				if (run_check) begin
					if (st_q.backoff_timer != '0) begin
						st_nxt.backoff_timer = st_q.backoff_timer - 8'd1;
					end else if (st_q.response_timer != '0) begin
						st_nxt.response_timer = st_q.response_timer - 4'd1;
					end else if (st_q.request_pending) begin
						st_nxt.request_pending = 1'b0;
					end else if (data_pending_s1) begin
						st_nxt.request_pending = 1'b1;
						st_nxt.response_timer  = response_window_q;
						res_nxt.rac_request    = 1'b1;
					end
				end
			end
			KIND_RESP: begin
				if (rac_success_s1) begin
					st_nxt.report_flag   = 1'b1;
					st_nxt.try_count     = '0;
					st_nxt.backoff_timer = '0;
				end else if (tries_inc >= {1'b0, max_tries_q}) begin
					st_nxt.try_count     = '0;
					st_nxt.backoff_timer = '0;
				end else begin
					st_nxt.try_count     = tries_inc[3:0];
					st_nxt.backoff_timer = draw_clamped;
				end
			end
			KIND_GRANT: begin
				st_nxt.grant_valid       = 1'b1;
				st_nxt.grant_is_periodic = grant_periodic_s1;
				st_nxt.request_pending   = 1'b0;
				if (grant_periodic_s1) begin
					st_nxt.period_counter = grant_period_s1;
					st_nxt.stored_period  = grant_period_s1;
					st_nxt.expiry_counter = grant_expiration_s1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				st_q <= st_nxt;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.rac_request    = res_s2.rac_request;
	assign rsp.tx_opportunity = res_s2.tx_opportunity;
	assign rsp.report_due     = res_s2.report_due;
	assign rsp.grant_expired  = res_s2.grant_expired;

endmodule

FILE: hw/rtl/ragt_checker.sv
// ----------------------------------------------------------------------------
// ragt_checker
// Port-level checks on result words of the random access and grant timer.
// ----------------------------------------------------------------------------
module ragt_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rac_request,
	input logic tx_opportunity,
	input logic report_due,
	input logic grant_expired
);

	// a stalled result word holds still
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid &&
		$stable({rac_request, tx_opportunity, report_due, grant_expired}))
		else $error("result word changed while stalled");

	// a request only goes out on a tick without a transmit opportunity
	a_req_vs_opp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rac_request && tx_opportunity))
		else $error("request and opportunity in one word");

	// report rides only on an opportunity
	a_report_opp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && report_due |-> tx_opportunity)
		else $error("report without opportunity");

	// a lapsing grant gives no opportunity
	a_expired_opp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && grant_expired |-> !tx_opportunity)
		else $error("opportunity on expired grant");

endmodule

bind random_access_and_grant_timer ragt_checker u_ragt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rac_request    (rsp.rac_request),
	.tx_opportunity (rsp.tx_opportunity),
	.report_due     (rsp.report_due),
	.grant_expired  (rsp.grant_expired)
);

FILE: verif/random_access_and_grant_timer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// random_access_and_grant_timer_test
// Drives event words into the uplink access/grant controller over valid/ready,
// predicts each result word from a local copy of the controller state and the
// registers, and compares every returned word field by field. Both channels
// idle and stall at random; one phase runs back to back with no gaps.
// ----------------------------------------------------------------------------
module random_access_and_grant_timer_test;
	import ragt_pkg::*;

	localparam int unsigned HALF_PERIOD = 6;
	localparam int unsigned RESET_CYCLES = 8;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PRINT_LIMIT = 40;

	typedef struct packed {
		kind_t       kind;
		logic        data_pending;
		logic        rac_success;
		logic [7:0]  backoff_draw;
		logic        grant_periodic;
		logic [9:0]  grant_period;
		logic [15:0] grant_expiration;
	} event_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ragt_evt_if evt_ch ();
	ragt_rsp_if rsp_ch ();

	random_access_and_grant_timer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.evt       (evt_ch),
		.rsp       (rsp_ch)
	);

	// local copy of the controller
	ctl_state_t  ctl;
	logic [3:0]  max_tries_reg;
	logic [7:0]  min_backoff_reg;
	logic [7:0]  max_backoff_reg;
	logic [3:0]  window_reg;

	result_t     expected_results[$];
	int unsigned words_sent;
	int unsigned results_seen;
	int unsigned errors;
	int unsigned idle_cycles;
	bit          no_gaps;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		// keep the log short when the block is badly broken
		if (errors < PRINT_LIMIT)
			$display("MISMATCH at result word %0d: %s", results_seen, what);
		errors++;
	endtask

	function automatic logic access_attempt(input logic data);
		if (ctl.backoff_timer != 8'd0) begin
			ctl.backoff_timer = ctl.backoff_timer - 8'd1;
			return 1'b0;
		end
		if (ctl.response_timer != 4'd0) begin
			ctl.response_timer = ctl.response_timer - 4'd1;
			return 1'b0;
		end
		if (ctl.request_pending) begin
			ctl.request_pending = 1'b0;
			return 1'b0;
		end
		if (data) begin
			ctl.request_pending = 1'b1;
			ctl.response_timer = window_reg;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic result_t predict_result(input event_word_t w);
		result_t    r;
		logic       give;
		logic [4:0] tries_next;
		logic [7:0] backoff;
		r = '0;
		give = 1'b0;
		case (w.kind)
			KIND_TICK: begin
				if (!ctl.grant_valid) begin
					r.rac_request = access_attempt(w.data_pending);
				end else if (ctl.grant_is_periodic) begin
					if (ctl.expiry_counter == 16'd0) begin
						ctl.grant_valid = 1'b0;
						ctl.grant_is_periodic = 1'b0;
						r.grant_expired = 1'b1;
						r.rac_request = access_attempt(w.data_pending);
					end else begin
						ctl.expiry_counter = ctl.expiry_counter - 16'd1;
						if (ctl.period_counter > 10'd1) begin
							ctl.period_counter = ctl.period_counter - 10'd1;
						end else begin
							ctl.period_counter = ctl.stored_period;
							give = 1'b1;
						end
					end
				end else begin
					give = 1'b1;
				end
				if (give) begin
					r.tx_opportunity = 1'b1;
					r.report_due = ctl.report_flag;
					ctl.report_flag = 1'b0;
					if (!ctl.grant_is_periodic)
						ctl.grant_valid = 1'b0;
				end
			end
			KIND_RESP: begin
				if (w.rac_success) begin
					ctl.report_flag = 1'b1;
					ctl.try_count = 4'd0;
					ctl.backoff_timer = 8'd0;
				end else begin
					tries_next = {1'b0, ctl.try_count} + 5'd1;
					if (tries_next >= {1'b0, max_tries_reg}) begin
						ctl.try_count = 4'd0;
						ctl.backoff_timer = 8'd0;
					end else begin
						ctl.try_count = tries_next[3:0];
						// min first, then max: max wins on an inverted range
						backoff = w.backoff_draw;
						if (backoff < min_backoff_reg)
							backoff = min_backoff_reg;
						if (backoff > max_backoff_reg)
							backoff = max_backoff_reg;
						ctl.backoff_timer = backoff;
					end
				end
			end
			KIND_GRANT: begin
				ctl.grant_valid = 1'b1;
				ctl.grant_is_periodic = w.grant_periodic;
				if (w.grant_periodic) begin
					ctl.period_counter = w.grant_period;
					ctl.stored_period = w.grant_period;
					ctl.expiry_counter = w.grant_expiration;
				end
				ctl.request_pending = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// called at a rising edge; returns at the edge where the word is taken
	task automatic send_word(input event_word_t w);
		while (!no_gaps && $urandom_range(99) < 29) begin
			evt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		evt_ch.kind             <= w.kind;
		evt_ch.data_pending     <= w.data_pending;
		evt_ch.rac_success      <= w.rac_success;
		evt_ch.backoff_draw     <= w.backoff_draw;
		evt_ch.grant_periodic   <= w.grant_periodic;
		evt_ch.grant_period     <= w.grant_period;
		evt_ch.grant_expiration <= w.grant_expiration;
		evt_ch.valid            <= 1'b1;
		do
			@(posedge clk);
		while (!evt_ch.ready);
		expected_results.insert(expected_results.size(), predict_result(w));
		words_sent++;
	endtask

	task automatic finish_phase();
		evt_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes all four registers; upper bits of the narrow ones carry noise
	task automatic configure(input logic [3:0] tries, input logic [7:0] bo_min,
			input logic [7:0] bo_max, input logic [3:0] window);
		finish_phase();
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_MAX_TRIES;
		cfg_wdata <= {4'($urandom_range(15)), tries};
		@(posedge clk);
		cfg_idx   <= CFG_MIN_BACKOFF;
		cfg_wdata <= bo_min;
		@(posedge clk);
		cfg_idx   <= CFG_MAX_BACKOFF;
		cfg_wdata <= bo_max;
		@(posedge clk);
		cfg_idx   <= CFG_RESPONSE_WINDOW;
		cfg_wdata <= {4'($urandom_range(15)), window};
		@(posedge clk);
		cfg_we <= 1'b0;
		max_tries_reg   = tries;
		min_backoff_reg = bo_min;
		max_backoff_reg = bo_max;
		window_reg      = window;
	endtask

	function automatic event_word_t make_word(input kind_t k, input logic dp,
			input logic succ, input logic [7:0] draw, input logic gper,
			input logic [9:0] gperiod, input logic [15:0] gexp);
		event_word_t w;
		w.kind = k;
		w.data_pending = dp;
		w.rac_success = succ;
		w.backoff_draw = draw;
		w.grant_periodic = gper;
		w.grant_period = gperiod;
		w.grant_expiration = gexp;
		return w;
	endfunction

	function automatic event_word_t random_word(input kind_t k);
		return make_word(k, 1'($urandom_range(1)), 1'($urandom_range(1)),
			8'($urandom_range(255)), 1'($urandom_range(1)),
			10'($urandom_range(1023)), 16'($urandom_range(65535)));
	endfunction

	function automatic kind_t pick_kind();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45)
			return KIND_TICK;
		if (r < 70)
			return KIND_RESP;
		if (r < 95)
			return KIND_GRANT;
		return KIND_NONE;
	endfunction

	task automatic test_access_directed();
		// reset registers: no retries, backoff 0..1, window 3
		send_word(make_word(KIND_TICK, 1'b0, 1'b0, 8'd0, 1'b0, 10'd0, 16'd0));
		send_word(make_word(KIND_TICK, 1'b1, 1'b0, 8'd0, 1'b0, 10'd0, 16'd0));
		repeat (4) send_word(make_word(KIND_TICK, 1'b1, 1'b0, 8'd0, 1'b0, 10'd0, 16'd0));
		send_word(make_word(KIND_TICK, 1'b1, 1'b0, 8'd0, 1'b0, 10'd0, 16'd0));
		send_word(make_word(KIND_RESP, 1'b0, 1'b0, 8'hff, 1'b0, 10'd0, 16'd0));
		send_word(make_word(KIND_RESP, 1'b0, 1'b1, 8'hff, 1'b0, 10'd0, 16'd0));
		send_word(make_word(KIND_NONE, 1'b1, 1'b1, 8'hff, 1'b1, 10'h3ff, 16'hffff));
		// inverted backoff range, most retries, no response window
		configure(4'd15, 8'd200, 8'd10, 4'd0);
		send_word(make_word(KIND_RESP, 1'b1, 1'b0, 8'hff, 1'b1, 10'h3ff, 16'hffff));
		send_word(make_word(KIND_RESP, 1'b0, 1'b0, 8'h00, 1'b0, 10'd0, 16'd0));
		send_word(make_word(KIND_TICK, 1'b1, 1'b0, 8'd0, 1'b0, 10'd0, 16'd0));
	endtask

	task automatic test_grant_directed();
		configure(4'd1, 8'd0, 8'd255, 4'd15);
		send_word(make_word(KIND_GRANT, 1'b1, 1'b1, 8'hff, 1'b0, 10'h3ff, 16'hffff));
		send_word(make_word(KIND_TICK, 1'b1, 1'b0, 8'd0, 1'b0, 10'd0, 16'd0));
		send_word(make_word(KIND_GRANT, 1'b0, 1'b0, 8'd0, 1'b1, 10'd0, 16'd0));
		send_word(make_word(KIND_TICK, 1'b1, 1'b0, 8'd0, 1'b0, 10'd0, 16'd0));
		send_word(make_word(KIND_RESP, 1'b0, 1'b1, 8'd0, 1'b0, 10'd0, 16'd0));
		send_word(make_word(KIND_GRANT, 1'b0, 1'b0, 8'd0, 1'b1, 10'd1, 16'd2));
		repeat (3) send_word(make_word(KIND_TICK, 1'b1, 1'b0, 8'd0, 1'b0, 10'd0, 16'd0));
		send_word(make_word(KIND_GRANT, 1'b0, 1'b0, 8'd0, 1'b1, 10'h3ff, 16'hffff));
		repeat (2) send_word(make_word(KIND_TICK, 1'b0, 1'b0, 8'd0, 1'b0, 10'd0, 16'd0));
	endtask

	// request / response exchanges with random timing content
	task automatic test_access_sequences(input int unsigned count);
		int unsigned target;
		event_word_t w;
		target = words_sent + count;
		while (words_sent < target) begin
			repeat ($urandom_range(1, 8)) begin
				w = random_word(KIND_TICK);
				w.data_pending = ($urandom_range(9) != 0);
				send_word(w);
			end
			w = random_word(KIND_RESP);
			w.rac_success = ($urandom_range(3) == 0);
			if ($urandom_range(3) != 0)
				w.backoff_draw = 8'($urandom_range(8));
			send_word(w);
			if ($urandom_range(9) == 0) begin
				w = random_word(KIND_GRANT);
				w.grant_periodic = 1'b0;
				send_word(w);
			end
			if ($urandom_range(7) == 0)
				send_word(random_word(pick_kind()));
		end
	endtask

	// grants followed by runs of ticks, short periods and expirations mostly
	task automatic test_grant_sequences(input int unsigned count);
		int unsigned target;
		event_word_t w;
		target = words_sent + count;
		while (words_sent < target) begin
			w = random_word(KIND_GRANT);
			w.grant_periodic = ($urandom_range(4) != 0);
			if ($urandom_range(9) != 0) begin
				w.grant_period = 10'($urandom_range(6));
				w.grant_expiration = 16'($urandom_range(24));
			end else begin
				w.grant_expiration = 16'($urandom_range(40));
			end
			send_word(w);
			repeat ($urandom_range(0, 30)) begin
				if ($urandom_range(5) == 0) begin
					w = random_word(KIND_RESP);
					w.rac_success = 1'b1;
				end else begin
					w = random_word(KIND_TICK);
				end
				send_word(w);
			end
		end
	endtask

	task automatic test_random_mix(input int unsigned count);
		event_word_t w;
		repeat (count) begin
			w = random_word(pick_kind());
			if (w.kind == KIND_GRANT && $urandom_range(3) != 0) begin
				w.grant_period = 10'($urandom_range(8));
				w.grant_expiration = 16'($urandom_range(30));
			end
			send_word(w);
		end
	endtask

	task automatic test_back_to_back(input int unsigned count);
		finish_phase();
		no_gaps = 1'b1;
		test_random_mix(count / 2);
		test_access_sequences(count / 2);
		no_gaps = 1'b0;
	endtask

	// result checker and sink stall
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = {rsp_ch.rac_request, rsp_ch.tx_opportunity, rsp_ch.report_due,
				rsp_ch.grant_expired};
			if (expected_results.size() == 0) begin
				report_mismatch("result word with none expected");
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				if (got.rac_request !== want.rac_request)
					report_mismatch($sformatf("rac_request got %b want %b",
						got.rac_request, want.rac_request));
				if (got.tx_opportunity !== want.tx_opportunity)
					report_mismatch($sformatf("tx_opportunity got %b want %b",
						got.tx_opportunity, want.tx_opportunity));
				if (got.report_due !== want.report_due)
					report_mismatch($sformatf("report_due got %b want %b",
						got.report_due, want.report_due));
				if (got.grant_expired !== want.grant_expired)
					report_mismatch($sformatf("grant_expired got %b want %b",
						got.grant_expired, want.grant_expired));
			end
			results_seen++;
		end
		rsp_ch.ready <= no_gaps || ($urandom_range(99) >= 29);
	end

	always @(posedge clk) begin
		if ((evt_ch.valid && evt_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_MAX_TRIES;
		cfg_wdata = '0;
		evt_ch.valid = 1'b0;
		evt_ch.kind = KIND_TICK;
		evt_ch.data_pending = 1'b0;
		evt_ch.rac_success = 1'b0;
		evt_ch.backoff_draw = '0;
		evt_ch.grant_periodic = 1'b0;
		evt_ch.grant_period = '0;
		evt_ch.grant_expiration = '0;
		rsp_ch.ready = 1'b0;
		idle_cycles = 0;
		words_sent = 0;
		results_seen = 0;
		errors = 0;
		no_gaps = 1'b0;
		ctl = '0;
		max_tries_reg = MAX_TRIES_RST;
		min_backoff_reg = MIN_BACKOFF_RST;
		max_backoff_reg = MAX_BACKOFF_RST;
		window_reg = RESPONSE_WINDOW_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_access_directed();
		test_grant_directed();
		configure(4'd4, 8'd1, 8'd6, 4'd2);
		test_access_sequences(300);
		configure(4'd0, 8'd0, 8'd0, 4'd0);
		test_access_sequences(150);
		configure(4'd15, 8'd255, 8'd255, 4'd15);
		test_grant_sequences(300);
		configure(4'($urandom_range(15)), 8'($urandom_range(8)),
			8'($urandom_range(255)), 4'($urandom_range(15)));
		test_random_mix(350);
		configure(4'd2, 8'd0, 8'd3, 4'd1);
		test_back_to_back(250);
		finish_phase();

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
